>>> rtl/page_writeback_counter_table_macros.svh
// Assertion macros for the page writeback counter table checker.
// Clock i_clk and active-low reset i_rst_n must be visible where they are used.
`ifndef PAGE_WRITEBACK_COUNTER_TABLE_MACROS_SVH
`define PAGE_WRITEBACK_COUNTER_TABLE_MACROS_SVH

// Same-cycle implication.
`define PWCT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PWCT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/pwct_pkg.sv
// Package: field widths, codes and types of the page writeback counter table.
`timescale 1ns / 1ps

package pwct_pkg;

    localparam int TYPE_W   = 2;
    localparam int ADDR_W   = 48;
    localparam int INDEX_W  = 6;
    localparam int STATUS_W = 3;
    localparam int PAGE_W   = 48;
    localparam int COUNT_W  = 32;
    localparam int USED_W   = 7;
    localparam int SHIFT_W  = 5;

    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd6;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int ADDR_BITS_DEF     = 48;
    localparam int COUNT_BITS_DEF    = 32;

    // Request kinds; the remaining code is treated as an other request.
    localparam logic [TYPE_W-1:0] REQ_OTHER     = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_WRITEBACK = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_READ      = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_IGNORED  = 3'd0,
        ST_NEW      = 3'd1,
        ST_INCR     = 3'd2,
        ST_FULL     = 3'd3,
        ST_READ_OK  = 3'd4,
        ST_READ_BAD = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_EMIT
    } t_state;

endpackage

>>> rtl/pwct_if.sv
// Interfaces: request and result channels of the page writeback counter table.
`timescale 1ns / 1ps

interface pwct_req_if;
    logic                          valid;
    logic                          ready;
    logic [pwct_pkg::TYPE_W-1:0]   req_type;
    logic [pwct_pkg::ADDR_W-1:0]   mem_addr;
    logic [pwct_pkg::INDEX_W-1:0]  read_index;

    modport source (output valid, output req_type, output mem_addr, output read_index,
                    input ready);
    modport sink   (input valid, input req_type, input mem_addr, input read_index,
                    output ready);
endinterface

interface pwct_res_if;
    logic                          valid;
    logic                          ready;
    logic [pwct_pkg::STATUS_W-1:0] status;
    logic [pwct_pkg::PAGE_W-1:0]   page_number;
    logic [pwct_pkg::COUNT_W-1:0]  write_count;
    logic [pwct_pkg::USED_W-1:0]   entries_used;

    modport source (output valid, output status, output page_number, output write_count,
                    output entries_used, input ready);
    modport sink   (input valid, input status, input page_number, input write_count,
                    input entries_used, output ready);
endinterface

>>> rtl/page_writeback_counter_table.sv
// Top level: per-page dirty writeback counter table with first-seen order read-out.
`timescale 1ns / 1ps

// Counts dirty writebacks per memory page. A writeback transaction (req_type 1)
// maps its line address to a page (line address >> page_shift); a known page has its
// counter bumped (saturating at the COUNT_BITS maximum), an unknown page is
// appended with count 1, or dropped with status "full" once TABLE_ENTRIES pages
// are held. A read transaction (req_type 2) returns the page and count at a
// first-seen position; positions at or past entries_used read as invalid. Any
// other request kind returns "ignored". Every transaction gives exactly one result.
// Tags and counts live in two single-port-write, registered-read memories that
// are never cleared: only entries below the fill count are ever looked at.
// Sequence: one transaction at a time, ready only while idle. Ignored requests and
// invalid reads go straight to the emit state, valid reads pass through the read
// state first, a writeback to an empty table is appended from the idle state, and
// any other writeback scans: the single tag comparator walks the entries one per
// cycle, stopping at the first hit or after every held entry on a miss. The result
// then sits in an output register until taken; while it is not taken, the next
// result waits in the emit state. page_shift may be written only while the block is idle.
module page_writeback_counter_table #(
    parameter int TABLE_ENTRIES = pwct_pkg::TABLE_ENTRIES_DEF,
    parameter int ADDR_BITS     = pwct_pkg::ADDR_BITS_DEF,
    parameter int COUNT_BITS    = pwct_pkg::COUNT_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [pwct_pkg::SHIFT_W-1:0] i_cfg_wdata,
    pwct_req_if.sink                     i_req,
    pwct_res_if.source                   o_res
);

    // Widths derived from the parameters.
    localparam int IW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int UW   = $clog2(TABLE_ENTRIES + 1);
    localparam int CMPW = (UW > pwct_pkg::INDEX_W) ? UW : pwct_pkg::INDEX_W;
    localparam int PW   = ADDR_BITS;
    localparam int CW   = COUNT_BITS;

    // Control state
    pwct_pkg::t_state              r_state, n_state;
    logic [IW-1:0]                 r_idx, n_idx;
    logic [UW-1:0]                 r_used, n_used;
    logic [pwct_pkg::SHIFT_W-1:0]  r_page_shift;

    // Page of the transaction in flight
    logic [PW-1:0]                 r_page;

    // Result being assembled
    pwct_pkg::t_status             r_res_status, n_res_status;
    logic [PW-1:0]                 r_res_page, n_res_page;
    logic [CW-1:0]                 r_res_count, n_res_count;

    // Output register
    logic                          r_out_valid;
    pwct_pkg::t_status             r_out_status;
    logic [pwct_pkg::PAGE_W-1:0]   r_out_page;
    logic [pwct_pkg::COUNT_W-1:0]  r_out_count;
    logic [pwct_pkg::USED_W-1:0]   r_out_used;

    // Tag and count memories
    logic [PW-1:0]                 tag_mem [TABLE_ENTRIES];
    logic [CW-1:0]                 cnt_mem [TABLE_ENTRIES];
    logic [PW-1:0]                 r_tag_q;
    logic [CW-1:0]                 r_cnt_q;

    logic                          wr_tag_en;
    logic                          wr_cnt_en;
    logic [IW-1:0]                 wr_addr;
    logic [PW-1:0]                 wr_tag;
    logic [CW-1:0]                 wr_cnt;

    logic [PW-1:0]                 page_calc;
    logic [IW-1:0]                 idx_in;
    logic                          idx_ok;
    logic                          tag_hit;
    logic                          scan_last;
    logic                          table_full;
    logic [CW-1:0]                 cnt_inc;
    logic                          out_free;
    logic                          load_out;
    logic                          in_accept;

    // Address is taken at ADDR_BITS, then shifted down to the page number.
    assign page_calc  = PW'(i_req.mem_addr) >> r_page_shift;
    assign idx_in     = IW'(i_req.read_index);
    assign idx_ok     = CMPW'(i_req.read_index) < CMPW'(r_used);
    assign tag_hit    = (r_tag_q == r_page);
    assign scan_last  = (UW'(r_idx) + UW'(1)) == r_used;
    assign table_full = (r_used == UW'(TABLE_ENTRIES));
    assign cnt_inc    = (r_cnt_q == {CW{1'b1}}) ? r_cnt_q : r_cnt_q + CW'(1);
    assign out_free   = !r_out_valid || o_res.ready;

    assign i_req.ready = (r_state == pwct_pkg::S_IDLE);
    assign in_accept   = i_req.valid && i_req.ready;

    // Sequencer: next state, memory writes and result assembly
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_used       = r_used;
        n_res_status = r_res_status;
        n_res_page   = r_res_page;
        n_res_count  = r_res_count;
        wr_tag_en    = 1'b0;
        wr_cnt_en    = 1'b0;
        wr_addr      = IW'(r_used);
        wr_tag       = r_page;
        wr_cnt       = CW'(1);
        load_out     = 1'b0;

        unique case (r_state)
            pwct_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    priority if (i_req.req_type == pwct_pkg::REQ_WRITEBACK) begin
                        n_res_page = page_calc;
                        if (r_used == '0) begin
                            // empty table: append right away
                            wr_tag_en    = 1'b1;
                            wr_cnt_en    = 1'b1;
                            wr_tag       = page_calc;
                            n_used       = r_used + UW'(1);
                            n_res_status = pwct_pkg::ST_NEW;
                            n_res_count  = CW'(1);
                            n_state      = pwct_pkg::S_EMIT;
                        end else begin
                            // entry 0 is read now, compared next cycle
                            n_idx   = '0;
                            n_state = pwct_pkg::S_SCAN;
                        end
                    end else if (i_req.req_type == pwct_pkg::REQ_READ) begin
                        if (idx_ok) begin
                            n_idx   = idx_in;
                            n_state = pwct_pkg::S_READ;
                        end else begin
                            n_res_status = pwct_pkg::ST_READ_BAD;
                            n_res_page   = '0;
                            n_res_count  = '0;
                            n_state      = pwct_pkg::S_EMIT;
                        end
                    end else begin
                        n_res_status = pwct_pkg::ST_IGNORED;
                        n_res_page   = '0;
                        n_res_count  = '0;
                        n_state      = pwct_pkg::S_EMIT;
                    end
                end
            end

            pwct_pkg::S_SCAN: begin
                // r_tag_q / r_cnt_q hold entry r_idx
                if (tag_hit) begin
                    wr_cnt_en    = 1'b1;
                    wr_addr      = r_idx;
                    wr_cnt       = cnt_inc;
                    n_res_status = pwct_pkg::ST_INCR;
                    n_res_page   = r_page;
                    n_res_count  = cnt_inc;
                    n_state      = pwct_pkg::S_EMIT;
                end else if (scan_last) begin
                    n_res_page = r_page;
                    n_state    = pwct_pkg::S_EMIT;
                    if (table_full) begin
                        n_res_status = pwct_pkg::ST_FULL;
                        n_res_count  = '0;
                    end else begin
                        wr_tag_en    = 1'b1;
                        wr_cnt_en    = 1'b1;
                        n_used       = r_used + UW'(1);
                        n_res_status = pwct_pkg::ST_NEW;
                        n_res_count  = CW'(1);
                    end
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end

            pwct_pkg::S_READ: begin
                n_res_status = pwct_pkg::ST_READ_OK;
                n_res_page   = r_tag_q;
                n_res_count  = r_cnt_q;
                n_state      = pwct_pkg::S_EMIT;
            end

            pwct_pkg::S_EMIT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = pwct_pkg::S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= pwct_pkg::S_IDLE;
            r_used       <= '0;
            r_page_shift <= pwct_pkg::SHIFT_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            if (i_cfg_we) begin
                r_page_shift <= i_cfg_wdata;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_res_status <= n_res_status;
        r_res_page   <= n_res_page;
        r_res_count  <= n_res_count;
        if (in_accept) begin
            r_page <= page_calc;
        end
        if (load_out) begin
            r_out_status <= r_res_status;
            r_out_page   <= pwct_pkg::PAGE_W'(r_res_page);
            r_out_count  <= pwct_pkg::COUNT_W'(r_res_count);
            r_out_used   <= pwct_pkg::USED_W'(r_used);
        end
    end

    // Memories: one write, one registered read each; read address is n_idx
    always_ff @(posedge i_clk) begin
        if (wr_tag_en) begin
            tag_mem[wr_addr] <= wr_tag;
        end
        r_tag_q <= tag_mem[n_idx];
    end

    always_ff @(posedge i_clk) begin
        if (wr_cnt_en) begin
            cnt_mem[wr_addr] <= wr_cnt;
        end
        r_cnt_q <= cnt_mem[n_idx];
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.status       = r_out_status;
    assign o_res.page_number  = r_out_page;
    assign o_res.write_count  = r_out_count;
    assign o_res.entries_used = r_out_used;

endmodule

>>> rtl/pwct_checker.sv
// Checker: port-level assertions for the page writeback counter table, with its bind.
`timescale 1ns / 1ps
`include "page_writeback_counter_table_macros.svh"

module pwct_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [pwct_pkg::STATUS_W-1:0] i_out_status,
    input logic [pwct_pkg::PAGE_W-1:0]   i_out_page,
    input logic [pwct_pkg::COUNT_W-1:0]  i_out_count,
    input logic [pwct_pkg::USED_W-1:0]   i_out_used
);

    // one transaction at a time: ready drops right after an accept
    `PWCT_ASSERT_NXT(a_busy_after_accept, i_in_valid && i_in_ready, !i_in_ready, "ready after accept")

    // stalled result holds
    `PWCT_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_status) && $stable(i_out_page) && $stable(i_out_count), "result changed while stalled")

    // ignored and invalid reads carry no page or count
    `PWCT_ASSERT_IMP(a_zero_payload, i_out_valid && (i_out_status == pwct_pkg::ST_IGNORED || i_out_status == pwct_pkg::ST_READ_BAD), i_out_page == '0 && i_out_count == '0, "nonzero payload on empty result")

    // a new page starts at one and occupies an entry
    `PWCT_ASSERT_IMP(a_new_page, i_out_valid && i_out_status == pwct_pkg::ST_NEW, i_out_count == pwct_pkg::COUNT_W'(1) && i_out_used != '0, "bad new page result")

endmodule

bind page_writeback_counter_table pwct_checker u_pwct_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_out_status (o_res.status),
    .i_out_page   (o_res.page_number),
    .i_out_count  (o_res.write_count),
    .i_out_used   (o_res.entries_used)
);

>>> tb/page_writeback_counter_table_test.sv
// Testbench for the page writeback counter table: directed and random traffic.
`timescale 1ns / 1ps

module page_writeback_counter_table_test;

    // Table depth as built with default parameters.
    localparam int TABLE_DEPTH = pwct_pkg::TABLE_ENTRIES_DEF;
    // The fourth request code has no name in the package; the block treats it as "other".
    localparam logic [pwct_pkg::TYPE_W-1:0] REQ_UNUSED = 2'd3;
    // Cycles with no transaction on either channel before the run is declared hung.
    // Worst case is a full-table scan plus long sender/receiver idle runs.
    localparam int WATCHDOG_LIMIT = 5000;
    // Random items per traffic phase, ignored requests included.
    localparam int PHASE_ITEMS = 282;
    // Cycles to let pass once nothing is outstanding (a full scan fits in this).
    localparam int SETTLE_CYCLES = 80;

    typedef struct packed {
        pwct_pkg::t_status                status;
        logic [pwct_pkg::PAGE_W-1:0]      page_number;
        logic [pwct_pkg::COUNT_W-1:0]     write_count;
        logic [pwct_pkg::USED_W-1:0]      entries_used;
    } t_wb_result;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [pwct_pkg::SHIFT_W-1:0] cfg_wdata;

    pwct_req_if wb_req ();
    pwct_res_if wb_res ();

    page_writeback_counter_table DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (wb_req),
        .o_res       (wb_res)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: a shadow of the page table and of page_shift.
    // ------------------------------------------------------------------
    logic [pwct_pkg::PAGE_W-1:0]  tag_mem   [TABLE_DEPTH];
    logic [pwct_pkg::COUNT_W-1:0] count_mem [TABLE_DEPTH];
    logic [pwct_pkg::USED_W-1:0]  pages_held = '0;
    logic [pwct_pkg::SHIFT_W-1:0] page_shift_q = pwct_pkg::SHIFT_RESET;

    // Results still owed by the block, oldest first.
    t_wb_result expected_results[$];

    int n_errors = 0;
    int send_idle_pct = 0;    // chance per cycle that the sender holds off
    int recv_stall_pct = 0;   // chance per cycle that the receiver stalls
    int quiet_cycles = 0;

    // Applies one request to the shadow table and returns the result it must produce.
    function automatic t_wb_result count_writeback(
        input logic [pwct_pkg::TYPE_W-1:0] kind,
        input logic [pwct_pkg::ADDR_W-1:0] addr,
        input logic [pwct_pkg::INDEX_W-1:0] idx);
        t_wb_result r;
        logic [pwct_pkg::PAGE_W-1:0] page;
        bit hit;
        r.status      = pwct_pkg::ST_IGNORED;
        r.page_number = '0;
        r.write_count = '0;
        if (kind == pwct_pkg::REQ_WRITEBACK) begin
            page = addr >> page_shift_q;
            hit  = 1'b0;
            // First-seen order: the earliest matching entry wins.
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (!hit && i < pages_held && tag_mem[i] == page) begin
                    hit = 1'b1;
                    if (count_mem[i] != '1)
                        count_mem[i] = count_mem[i] + 1'b1;   // saturates at all ones
                    r.status      = pwct_pkg::ST_INCR;
                    r.page_number = page;
                    r.write_count = count_mem[i];
                end
            end
            if (!hit) begin
                r.page_number = page;
                if (pages_held >= TABLE_DEPTH) begin
                    r.status = pwct_pkg::ST_FULL;              // dropped, nothing stored
                end else begin
                    tag_mem[pages_held]   = page;
                    count_mem[pages_held] = pwct_pkg::COUNT_W'(1);
                    pages_held            = pages_held + 1'b1;
                    r.status              = pwct_pkg::ST_NEW;
                    r.write_count         = pwct_pkg::COUNT_W'(1);
                end
            end
        end else if (kind == pwct_pkg::REQ_READ) begin
            if (idx < pages_held) begin
                r.status      = pwct_pkg::ST_READ_OK;
                r.page_number = tag_mem[idx];
                r.write_count = count_mem[idx];
            end else begin
                r.status = pwct_pkg::ST_READ_BAD;
            end
        end
        r.entries_used = pages_held;
        return r;
    endfunction

    function automatic logic [pwct_pkg::ADDR_W-1:0] random_addr();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[pwct_pkg::ADDR_W-1:0];
    endfunction

    function automatic logic [pwct_pkg::INDEX_W-1:0] random_index();
        logic [31:0] r;
        r = $urandom;
        return r[pwct_pkg::INDEX_W-1:0];
    endfunction

    // Random line address that lands in the given page under the current shift.
    function automatic logic [pwct_pkg::ADDR_W-1:0] addr_in_page(
        input logic [pwct_pkg::PAGE_W-1:0] page);
        logic [63:0] wide;
        logic [63:0] offs;
        wide = {16'd0, page} << page_shift_q;
        offs = {$urandom, $urandom} & ((64'd1 << page_shift_q) - 64'd1);
        wide = wide | offs;
        return wide[pwct_pkg::ADDR_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Request side: one transaction per call, with random hold-off first.
    // valid is left high after acceptance; drain or the next call's hold-off lowers it,
    // or the next request replaces it; valid never sees two assignments in one time step.
    // ------------------------------------------------------------------
    task automatic send_request(input logic [pwct_pkg::TYPE_W-1:0] kind,
                                input logic [pwct_pkg::ADDR_W-1:0] addr,
                                input logic [pwct_pkg::INDEX_W-1:0] idx);
        t_wb_result want;
        while ($urandom_range(99) < send_idle_pct) begin
            wb_req.valid <= 1'b0;
            @(posedge clk);
        end
        wb_req.valid      <= 1'b1;
        wb_req.req_type   <= kind;
        wb_req.mem_addr   <= addr;
        wb_req.read_index <= idx;
        @(posedge clk);
        while (!wb_req.ready)
            @(posedge clk);
        // Accepted at this edge: predict now, in the same step, so drains see it.
        want = count_writeback(kind, addr, idx);
        expected_results.insert(expected_results.size(), want);
    endtask

    // Stop sending, wait until every owed result has come back, then settle.
    task automatic drain_results(input int settle);
        wb_req.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // page_shift may only change while the block is idle.
    task automatic write_page_shift(input logic [pwct_pkg::SHIFT_W-1:0] value);
        drain_results(4);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we       <= 1'b0;
        page_shift_q  = value;
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure and in-order checking.
    // ------------------------------------------------------------------
    always @(posedge clk)
        wb_res.ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk) begin : check_results
        t_wb_result want;
        if (rst_n && wb_res.valid && wb_res.ready) begin
            if (expected_results.size() == 0) begin
                n_errors++;
                $error("result with nothing outstanding: status %0d page %0h",
                       wb_res.status, wb_res.page_number);
            end else begin
                want = expected_results.pop_front();
                if (wb_res.status !== want.status) begin
                    n_errors++;
                    $error("status: expected %0d, got %0d", want.status, wb_res.status);
                end
                if (wb_res.page_number !== want.page_number) begin
                    n_errors++;
                    $error("page_number: expected %0h, got %0h",
                           want.page_number, wb_res.page_number);
                end
                if (wb_res.write_count !== want.write_count) begin
                    n_errors++;
                    $error("write_count: expected %0d, got %0d",
                           want.write_count, wb_res.write_count);
                end
                if (wb_res.entries_used !== want.entries_used) begin
                    n_errors++;
                    $error("entries_used: expected %0d, got %0d",
                           want.entries_used, wb_res.entries_used);
                end
            end
        end
    end

    // Hang detector: any transaction on either channel resets the count.
    always @(posedge clk) begin
        if ((wb_req.valid && wb_req.ready) || (wb_res.valid && wb_res.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset shift (6): ignored kinds, reads of an empty table, new page, same-page hit,
    // top-of-range address, reads inside and past the fill count.
    task automatic test_request_kinds;
        send_request(pwct_pkg::REQ_OTHER, '1, '1);
        send_request(REQ_UNUSED, '1, '0);
        send_request(pwct_pkg::REQ_READ, '0, 6'd0);
        send_request(pwct_pkg::REQ_READ, '1, 6'd63);
        send_request(pwct_pkg::REQ_WRITEBACK, '0, '0);
        send_request(pwct_pkg::REQ_WRITEBACK, 48'h3F, '1);    // same page as line 0
        send_request(pwct_pkg::REQ_WRITEBACK, '1, '0);
        send_request(pwct_pkg::REQ_WRITEBACK, 48'h40, '1);
        send_request(pwct_pkg::REQ_READ, '0, 6'd0);
        send_request(pwct_pkg::REQ_READ, '0, 6'd1);
        send_request(pwct_pkg::REQ_READ, '1, 6'd2);
        send_request(pwct_pkg::REQ_READ, '0, 6'd3);           // at the fill count: first invalid position
    endtask

    // Shift extremes: 0 keeps the whole address, 31 folds most addresses onto low pages.
    task automatic test_shift_extremes;
        send_idle_pct  = 22;
        recv_stall_pct = 22;
        write_page_shift(5'd0);
        send_request(pwct_pkg::REQ_WRITEBACK, '1, '0);
        send_request(pwct_pkg::REQ_WRITEBACK, '1, '0);
        send_request(pwct_pkg::REQ_WRITEBACK, 48'h1, '0);
        send_request(pwct_pkg::REQ_READ, '0, 6'd4);
        write_page_shift(5'd31);
        send_request(pwct_pkg::REQ_WRITEBACK, '1, '0);
        send_request(pwct_pkg::REQ_WRITEBACK, 48'h7FFF_FFFF, '0);  // page 0
        send_request(pwct_pkg::REQ_WRITEBACK, 48'h8000_0000, '0);  // page 1 again
        send_request(pwct_pkg::REQ_READ, '0, 6'd5);
        send_request(pwct_pkg::REQ_READ, '0, 6'd6);
        send_request(REQ_UNUSED, '0, '1);
    endtask

    // Writebacks, largely to pages already held (deep scans, hits at any position),
    // some fresh pages that fill the table and then get dropped, reads around
    // the fill count, and a little ignored noise.
    task automatic run_traffic_phase(input int idle_pct, input int stall_pct,
                                     input logic [pwct_pkg::SHIFT_W-1:0] shift,
                                     input int n_items);
        int sent;
        int roll;
        int pick;
        logic [pwct_pkg::ADDR_W-1:0] addr;
        write_page_shift(shift);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_items) begin
            roll = $urandom_range(99);
            if (roll < 10) begin
                send_request(roll < 5 ? pwct_pkg::REQ_OTHER : REQ_UNUSED,
                             random_addr(), random_index());
                sent++;
            end else if (roll < 65) begin
                if (pages_held != 0 && roll < 50)
                    addr = addr_in_page(tag_mem[$urandom_range(pages_held - 1)]);
                else
                    addr = random_addr();
                send_request(pwct_pkg::REQ_WRITEBACK, addr, random_index());
                sent++;
            end else begin
                // Bias reads toward the valid range and its edge.
                pick = ($urandom_range(3) == 0) ? $urandom_range(63)
                                                : $urandom_range(pages_held);
                if (pick > 63)
                    pick = 63;
                send_request(pwct_pkg::REQ_READ, random_addr(),
                             pick[pwct_pkg::INDEX_W-1:0]);
                sent++;
            end
        end
    endtask

    task automatic test_random_traffic;
        run_traffic_phase(0, 0, 5'd12, PHASE_ITEMS);
        run_traffic_phase(74, 0, 5'd30, PHASE_ITEMS);
        run_traffic_phase(0, 74, 5'd0, PHASE_ITEMS);
        run_traffic_phase(22, 22, pwct_pkg::SHIFT_W'($urandom_range(31)), PHASE_ITEMS);
    endtask

    initial begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        wb_req.valid      = 1'b0;
        wb_req.req_type   = pwct_pkg::REQ_OTHER;
        wb_req.mem_addr   = '0;
        wb_req.read_index = '0;
        wb_res.ready      = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_request_kinds();
        test_shift_extremes();
        test_random_traffic();

        drain_results(SETTLE_CYCLES);
        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/pwct_pkg.sv
rtl/pwct_if.sv
rtl/page_writeback_counter_table.sv
rtl/pwct_checker.sv
tb/page_writeback_counter_table_test.sv
